// ----- hw/rtl/bba_pkg.sv -----
// block bitmap allocator: shared field widths, command/status/register codes
// and the controller-to-datapath command and status structs
// no dependencies
`default_nettype none

package bba_pkg;

    // field and register widths
    localparam int CMD_W      = 2;
    localparam int BLK_W      = 10;
    localparam int STAT_W     = 2;
    localparam int TOTAL_W    = 11;
    localparam int INODE_W    = 12;
    localparam int DATA_W     = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // map word geometry
    localparam int WORD_W  = 32;
    localparam int WORD_SH = 5;

    // scan bound never exceeds what an 11-bit total_blocks can reach
    localparam int SCAN_CAP = 2048;
    localparam int LIM_W    = 12;

    // data region bounds: widest start plus widest length
    localparam int RGN_W = 13;

    // fixed blocks ahead of the data region (boot, super, log, map header)
    localparam int REGION_BIAS = 4;

    // commands
    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MARK  = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK           = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_FREE      = 2'd1;
    localparam logic [STAT_W-1:0] ST_INVALID      = 2'd2;
    localparam logic [STAT_W-1:0] ST_ALREADY_FREE = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA  = 2'd2;

    // configuration reset values
    localparam logic [TOTAL_W-1:0] TOTAL_RST = 11'd1024;
    localparam logic [INODE_W-1:0] INODE_RST = 12'd200;
    localparam logic [DATA_W-1:0]  DATA_RST  = 11'd965;

    // controller to datapath
    typedef struct packed {
        logic start;     // latch the accepted beat, restart the scan
        logic scan;      // step the map scan
        logic update;    // write back the map word, form the result
        logic load_out;  // move the result into the output register
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_hit;  // a clear bit was found this cycle
        logic scan_end;  // scan ran past the bound without a hit
    } t_dp_stat;

endpackage

`default_nettype wire

// ----- hw/rtl/bba_ram.sv -----
// generic single-port-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- hw/rtl/bba_ctrl.sv -----
// block bitmap allocator controller: sequences fetch, scan, write-back and reply
// depends on bba_pkg
`default_nettype none

module bba_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [bba_pkg::CMD_W-1:0]    i_cmd,
    input  logic                         i_out_stall,
    output logic                         o_out_valid,
    input  bba_pkg::t_dp_stat            i_stat,
    output bba_pkg::t_dp_cmd             o_dp_cmd
);

    import bba_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_FETCH  = 5'b00010,
        S_SCAN   = 5'b00100,
        S_UPDATE = 5'b01000,
        S_REPLY  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   in_take;
    logic   out_free;

    // handshake
    assign in_take     = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    // next state and datapath commands
    always_comb begin
        n_state  = r_state;
        o_dp_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    o_dp_cmd.start = 1'b1;
                    n_state = (i_cmd == CMD_ALLOC) ? S_SCAN : S_FETCH;
                end
            end
            S_FETCH: begin
                n_state = S_UPDATE;
            end
            S_SCAN: begin
                o_dp_cmd.scan = 1'b1;
                if (i_stat.scan_hit || i_stat.scan_end) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_dp_cmd.update = 1'b1;
                if (out_free) begin
                    o_dp_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_REPLY;
                end
            end
            S_REPLY: begin
                if (out_free) begin
                    o_dp_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output beat valid
    assign n_out_valid = o_dp_cmd.load_out || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTH
    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dp_cmd.load_out |-> (!r_out_valid || !i_out_stall))
        else $error("result loaded over a stalled output beat");

    // hit and end of scan are exclusive
    a_scan_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !(i_stat.scan_hit && i_stat.scan_end))
        else $error("scan reported both hit and end");

    // write-back happens exactly once per item
    a_update_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPDATE) |=> (r_state != S_UPDATE))
        else $error("map write-back repeated");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/bba_dp.sv -----
// block bitmap allocator datapath: config registers, region bounds, used map
// ram with per-word valid bits, first-fit scan and result registers
// depends on bba_pkg and bba_ram
`default_nettype none

module bba_dp #(
    parameter int MAX_BLOCKS         = 1024,
    parameter int INODES_PER_BLOCK   = 8,
    parameter int BITS_PER_MAP_BLOCK = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  bba_pkg::t_dp_cmd                i_dp_cmd,
    output bba_pkg::t_dp_stat               o_stat,
    input  logic [bba_pkg::CMD_W-1:0]       i_cmd,
    input  logic [bba_pkg::BLK_W-1:0]       i_block_number,
    input  logic                            i_cfg_valid,
    input  logic [bba_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bba_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic [bba_pkg::STAT_W-1:0]      o_status,
    output logic [bba_pkg::BLK_W-1:0]       o_allocated_block
);

    import bba_pkg::*;

    // map geometry; blocks past the scan cap are never reached
    localparam int SCAN_BLOCKS = (MAX_BLOCKS < SCAN_CAP) ? MAX_BLOCKS : SCAN_CAP;
    localparam int WORDS       = (SCAN_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int AW          = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int ICW         = $clog2(WORDS + 1);
    localparam int FW          = AW + WORD_SH;

    // reciprocal constants for the two region divisions
    localparam int INODE_SH  = INODE_W + $clog2(INODES_PER_BLOCK);
    localparam int INODE_RW  = INODE_W + 2;
    localparam int INODE_PW  = INODE_W + INODE_RW;
    localparam logic [INODE_RW-1:0] INODE_RCP = INODE_RW'(
        ((64'd1 << INODE_SH) + 64'(INODES_PER_BLOCK) - 64'd1) / 64'(INODES_PER_BLOCK));
    localparam int TOTAL_SH  = TOTAL_W + $clog2(BITS_PER_MAP_BLOCK);
    localparam int TOTAL_RW  = TOTAL_W + 2;
    localparam int TOTAL_PW  = TOTAL_W + TOTAL_RW;
    localparam logic [TOTAL_RW-1:0] TOTAL_RCP = TOTAL_RW'(
        ((64'd1 << TOTAL_SH) + 64'(BITS_PER_MAP_BLOCK) - 64'd1) / 64'(BITS_PER_MAP_BLOCK));

    // bound values that match the reset configuration
    localparam int INODE_Q_RST = int'(INODE_RST) / INODES_PER_BLOCK;
    localparam int TOTAL_Q_RST = int'(TOTAL_RST) / BITS_PER_MAP_BLOCK;
    localparam int FIRST_RST   = REGION_BIAS + INODE_Q_RST + TOTAL_Q_RST;
    localparam int LAST_RST    = FIRST_RST + int'(DATA_RST);

    function automatic logic [WORD_SH-1:0] f_lowest(input logic [WORD_W-1:0] vec);
        logic [WORD_SH-1:0] idx;
        idx = '0;
        for (int k = WORD_W - 1; k >= 0; k--) begin
            if (vec[k]) begin
                idx = WORD_SH'(k);
            end
        end
        return idx;
    endfunction

    // configuration
    logic [TOTAL_W-1:0] r_total_blocks;
    logic [INODE_W-1:0] r_inode_count;
    logic [DATA_W-1:0]  r_data_blocks;

    // region bound pipeline
    logic [INODE_PW-1:0] inode_prod;
    logic [TOTAL_PW-1:0] total_prod;
    logic [INODE_W-1:0]  r_inode_q;
    logic [TOTAL_W-1:0]  r_total_q;
    logic [RGN_W-1:0]    first_sum;
    logic [RGN_W-1:0]    r_first;
    logic [RGN_W-1:0]    r_last;

    // accepted beat
    logic [CMD_W-1:0] r_cmd;
    logic [BLK_W-1:0] r_blk;

    // map ram and valid bits
    logic [WORDS-1:0]  r_word_valid;
    logic              r_rd_valid;
    logic [AW-1:0]     ram_raddr;
    logic [WORD_W-1:0] ram_rdata;
    logic [WORD_W-1:0] rd_word;
    logic              ram_we;

    // scan
    logic [LIM_W-1:0]   limit;
    logic [LIM_W-1:0]   n_words;
    logic [LIM_W-1:0]   word_base;
    logic [LIM_W-1:0]   word_left;
    logic [WORD_W-1:0]  tail_mask;
    logic [WORD_W-1:0]  free_vec;
    logic [WORD_SH-1:0] hit_bit;
    logic               issue_more;
    logic               scan_hit;
    logic [ICW-1:0]     r_issue_cnt;
    logic               r_pend;
    logic [AW-1:0]      r_pend_addr;
    logic               r_hit;
    logic [AW-1:0]      r_hit_addr;
    logic [WORD_SH-1:0] r_hit_bit;
    logic [WORD_W-1:0]  r_hit_word;
    logic [FW-1:0]      found;

    // free and mark
    logic [AW-1:0]     blk_word;
    logic [WORD_W-1:0] blk_mask;
    logic              blk_ok;
    logic              rgn_blk;
    logic              rgn_found;

    // write-back and result
    logic              upd_we;
    logic [AW-1:0]     upd_waddr;
    logic [WORD_W-1:0] upd_wdata;
    logic [STAT_W-1:0] upd_status;
    logic [BLK_W-1:0]  upd_block;
    logic [STAT_W-1:0] r_res_status;
    logic [BLK_W-1:0]  r_res_block;
    logic [STAT_W-1:0] r_out_status;
    logic [BLK_W-1:0]  r_out_block;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_blocks <= TOTAL_RST;
            r_inode_count  <= INODE_RST;
            r_data_blocks  <= DATA_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TOTAL: r_total_blocks <= i_cfg_data[TOTAL_W-1:0];
                CFG_INODE: r_inode_count  <= i_cfg_data[INODE_W-1:0];
                CFG_DATA:  r_data_blocks  <= i_cfg_data[DATA_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // region bounds: divide by reciprocal multiply, then sum
    assign inode_prod = INODE_PW'(r_inode_count) * INODE_PW'(INODE_RCP);
    assign total_prod = TOTAL_PW'(r_total_blocks) * TOTAL_PW'(TOTAL_RCP);
    assign first_sum  = RGN_W'(REGION_BIAS) + RGN_W'(r_inode_q) + RGN_W'(r_total_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inode_q <= INODE_W'(INODE_Q_RST);
            r_total_q <= TOTAL_W'(TOTAL_Q_RST);
            r_first   <= RGN_W'(FIRST_RST);
            r_last    <= RGN_W'(LAST_RST);
        end else begin
            r_inode_q <= INODE_W'(inode_prod >> INODE_SH);
            r_total_q <= TOTAL_W'(total_prod >> TOTAL_SH);
            r_first   <= first_sum;
            r_last    <= first_sum + RGN_W'(r_data_blocks);
        end
    end

    // accepted beat
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.start) begin
            r_cmd <= i_cmd;
            r_blk <= i_block_number;
        end
    end

    // map read: scan address while scanning, else the addressed block's word
    assign blk_word  = AW'(r_blk >> WORD_SH);
    assign blk_mask  = WORD_W'(1) << r_blk[WORD_SH-1:0];
    assign ram_raddr = i_dp_cmd.scan ? AW'(r_issue_cnt) : blk_word;
    assign rd_word   = r_rd_valid ? ram_rdata : '0;

    bba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (upd_waddr),
        .i_wdata (upd_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // a word never written reads as all free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_valid <= '0;
            r_rd_valid   <= 1'b0;
        end else begin
            r_rd_valid <= (32'(ram_raddr) < 32'(WORDS)) && r_word_valid[ram_raddr];
            if (ram_we) begin
                r_word_valid[upd_waddr] <= 1'b1;
            end
        end
    end

    // scan bound and per-word tail mask
    assign limit      = (LIM_W'(r_total_blocks) < LIM_W'(SCAN_BLOCKS))
                        ? LIM_W'(r_total_blocks) : LIM_W'(SCAN_BLOCKS);
    assign n_words    = (limit + LIM_W'(WORD_W - 1)) >> WORD_SH;
    assign word_base  = LIM_W'(r_pend_addr) << WORD_SH;
    assign word_left  = limit - word_base;
    assign tail_mask  = (word_left >= LIM_W'(WORD_W)) ? '1
                        : ((WORD_W'(1) << word_left[WORD_SH-1:0]) - WORD_W'(1));
    assign free_vec   = ~rd_word & tail_mask;
    assign hit_bit    = f_lowest(free_vec);
    assign issue_more = LIM_W'(r_issue_cnt) < n_words;
    assign scan_hit   = r_pend && (|free_vec);

    assign o_stat.scan_hit = scan_hit;
    assign o_stat.scan_end = !issue_more && !scan_hit;

    // scan: read one word per cycle, test the word read the cycle before
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue_cnt <= '0;
            r_pend      <= 1'b0;
            r_hit       <= 1'b0;
        end else if (i_dp_cmd.start) begin
            r_issue_cnt <= '0;
            r_pend      <= 1'b0;
            r_hit       <= 1'b0;
        end else if (i_dp_cmd.scan) begin
            if (issue_more) begin
                r_issue_cnt <= r_issue_cnt + ICW'(1);
                r_pend      <= 1'b1;
                r_pend_addr <= AW'(r_issue_cnt);
            end else begin
                r_pend <= 1'b0;
            end
            if (scan_hit) begin
                r_hit      <= 1'b1;
                r_hit_addr <= r_pend_addr;
                r_hit_bit  <= hit_bit;
                r_hit_word <= rd_word | (WORD_W'(1) << hit_bit);
            end
        end
    end

    // region checks
    assign found     = {r_hit_addr, r_hit_bit};
    assign blk_ok    = 32'(r_blk) < 32'(MAX_BLOCKS);
    assign rgn_blk   = (RGN_W'(r_blk) >= r_first) && (RGN_W'(r_blk) < r_last);
    assign rgn_found = (RGN_W'(found) >= r_first) && (RGN_W'(found) < r_last);

    // write-back word and result per command
    always_comb begin
        upd_we     = 1'b0;
        upd_waddr  = blk_word;
        upd_wdata  = rd_word;
        upd_status = ST_INVALID;
        upd_block  = '0;
        unique case (r_cmd)
            CMD_ALLOC: begin
                if (r_hit) begin
                    upd_we     = 1'b1;
                    upd_waddr  = r_hit_addr;
                    upd_wdata  = r_hit_word;
                    upd_status = rgn_found ? ST_OK : ST_INVALID;
                    upd_block  = BLK_W'(found);
                end else begin
                    upd_status = ST_NO_FREE;
                end
            end
            CMD_FREE: begin
                if (blk_ok && rgn_blk) begin
                    upd_we     = 1'b1;
                    upd_wdata  = rd_word & ~blk_mask;
                    upd_status = (|(rd_word & blk_mask)) ? ST_OK : ST_ALREADY_FREE;
                end
            end
            CMD_MARK: begin
                if (blk_ok) begin
                    upd_we     = 1'b1;
                    upd_wdata  = rd_word | blk_mask;
                    upd_status = ST_OK;
                end
            end
            default: begin
                upd_status = ST_INVALID;
            end
        endcase
    end

    assign ram_we = i_dp_cmd.update && upd_we;

    // result hold and output register
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.update) begin
            r_res_status <= upd_status;
            r_res_block  <= upd_block;
        end
        if (i_dp_cmd.load_out) begin
            r_out_status <= i_dp_cmd.update ? upd_status : r_res_status;
            r_out_block  <= i_dp_cmd.update ? upd_block : r_res_block;
        end
    end

    assign o_status          = r_out_status;
    assign o_allocated_block = r_out_block;

`ifndef SYNTH
    // map writes stay inside the map
    a_waddr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (32'(upd_waddr) < 32'(WORDS)))
        else $error("map write beyond last word");

    // data region end never wraps below its start
    a_region_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_last >= r_first)
        else $error("data region bounds out of order");

    // a hit lies below the scan bound
    a_hit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_dp_cmd.scan && scan_hit) |-> ((LIM_W'(r_pend_addr) << WORD_SH)
            + LIM_W'(hit_bit) < limit))
        else $error("scan hit past total_blocks");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/block_bitmap_allocator.sv -----
// First-fit block bitmap allocator. One beat in gives one beat out. Free, mark
// and the unused command fetch the addressed map word, then form the result
// and write the word back where the command is valid. Allocate reads the used
// map one 32-bit word per cycle from its ram and tests each word the cycle
// after; the scan ends at the first hit or when the words below
// min(total_blocks, MAX_BLOCKS) run out. The next beat is accepted the cycle
// after the result enters the output register, which holds it while the
// output is stalled. The map reads as all free after reset with no clearing
// pass. Configuration writes are always taken; region bounds settle through
// the quotient and bound registers after a write.
// depends on bba_pkg, bba_ctrl, bba_dp, bba_ram
`default_nettype none

module block_bitmap_allocator #(
    parameter int MAX_BLOCKS         = 1024,
    parameter int INODES_PER_BLOCK   = 8,
    parameter int BITS_PER_MAP_BLOCK = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [bba_pkg::CMD_W-1:0]       i_cmd,
    input  logic [bba_pkg::BLK_W-1:0]       i_block_number,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [bba_pkg::STAT_W-1:0]      o_status,
    output logic [bba_pkg::BLK_W-1:0]       o_allocated_block,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bba_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bba_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    import bba_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // configuration registers accept a beat every cycle
    assign o_cfg_ready = 1'b1;

    // sequencer
    bba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cmd       (i_cmd),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .i_stat      (dp_stat),
        .o_dp_cmd    (dp_cmd)
    );

    // map, scan and result datapath
    bba_dp #(
        .MAX_BLOCKS         (MAX_BLOCKS),
        .INODES_PER_BLOCK   (INODES_PER_BLOCK),
        .BITS_PER_MAP_BLOCK (BITS_PER_MAP_BLOCK)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_dp_cmd          (dp_cmd),
        .o_stat            (dp_stat),
        .i_cmd             (i_cmd),
        .i_block_number    (i_block_number),
        .i_cfg_valid       (i_cfg_valid && o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_status          (o_status),
        .o_allocated_block (o_allocated_block)
    );

endmodule

`default_nettype wire

// ----- tb/bba_checker.sv -----
`timescale 1ns / 100ps
// result checker for the block bitmap allocator: watches the command, result
// and register channels, keeps its own used map and compares every result beat
// depends on bba_pkg

module bba_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic [bba_pkg::CMD_W-1:0]      i_cmd,
    input  logic [bba_pkg::BLK_W-1:0]      i_block_number,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic [bba_pkg::STAT_W-1:0]     i_status,
    input  logic [bba_pkg::BLK_W-1:0]      i_allocated_block,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [bba_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bba_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_pending,
    output int                             o_fail_count
);

    import bba_pkg::*;

    localparam int MAP_BLOCKS     = 1024;
    localparam int INODES_PER_BLK = 8;
    localparam int BITS_PER_MAP   = 4096;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [BLK_W-1:0]  blk_no;
    } t_reply;

    // shadow of the volume geometry and the used map
    logic [TOTAL_W-1:0]    cfg_total;
    logic [INODE_W-1:0]    cfg_inode;
    logic [DATA_W-1:0]     cfg_data;
    logic [MAP_BLOCKS-1:0] used_bits;

    t_reply reply_q[$];
    int     mismatches = 0;

    // data region: boot, super, inode area, log, map area, then data blocks
    function automatic bit in_region(input int b);
        int first;
        first = 2 + int'(cfg_inode) / INODES_PER_BLK + 1 + int'(cfg_total) / BITS_PER_MAP + 1;
        return b >= first && b < first + int'(cfg_data);
    endfunction

    // apply one command to the shadow map and form its reply
    function automatic t_reply run_command(input logic [CMD_W-1:0] cmd,
                                           input logic [BLK_W-1:0] blk);
        t_reply r;
        int     lim;
        int     b;
        bit     hit;
        r.status = ST_OK;
        r.blk_no = '0;
        hit      = 1'b0;
        case (cmd)
            CMD_ALLOC: begin
                // first fit, scan bound capped at the map size
                lim      = cfg_total < MAP_BLOCKS ? int'(cfg_total) : MAP_BLOCKS;
                r.status = ST_NO_FREE;
                for (b = 0; b < lim && !hit; b++) begin
                    if (!used_bits[b]) begin
                        hit          = 1'b1;
                        used_bits[b] = 1'b1;
                        r.blk_no     = b[BLK_W-1:0];
                        r.status     = in_region(b) ? ST_OK : ST_INVALID;
                    end
                end
            end
            CMD_FREE: begin
                // a 10-bit block number never lies beyond the map
                if (!in_region(int'(blk))) begin
                    r.status = ST_INVALID;
                end else begin
                    if (!used_bits[blk])
                        r.status = ST_ALREADY_FREE;
                    used_bits[blk] = 1'b0;
                end
            end
            CMD_MARK: begin
                used_bits[blk] = 1'b1;
            end
            default: begin
                r.status = ST_INVALID;
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_reply want;
        if (!i_rst_n) begin
            cfg_total = TOTAL_RST;
            cfg_inode = INODE_RST;
            cfg_data  = DATA_RST;
            used_bits = '0;
            reply_q.delete();
        end else begin
            // result beat against the oldest reply
            if (i_out_valid && !i_out_stall) begin
                if (reply_q.size() == 0) begin
                    $error("result beat with nothing expected: status %0d block %0d",
                           i_status, i_allocated_block);
                    mismatches++;
                end else begin
                    want = reply_q.pop_front();
                    if (i_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_status);
                        mismatches++;
                    end
                    if (i_allocated_block !== want.blk_no) begin
                        $error("allocated_block: expected %0d, got %0d",
                               want.blk_no, i_allocated_block);
                        mismatches++;
                    end
                end
            end
            // register writes
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_TOTAL: cfg_total = i_cfg_data[TOTAL_W-1:0];
                    CFG_INODE: cfg_inode = i_cfg_data[INODE_W-1:0];
                    CFG_DATA:  cfg_data  = i_cfg_data[DATA_W-1:0];
                    default:   ;
                endcase
            end
            // command beat
            if (i_in_valid && !i_in_stall)
                reply_q.push_back(run_command(i_cmd, i_block_number));
        end
        o_pending    <= reply_q.size();
        o_fail_count <= mismatches;
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// top of the block bitmap allocator testbench: clock, reset, command and
// register stimulus, result back-pressure and the verdict
// depends on bba_pkg, block_bitmap_allocator and bba_checker

module testbench;

    import bba_pkg::*;

    localparam int                   MAP_BLOCKS = 1024;
    localparam logic [CMD_W-1:0]     CMD_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [CMD_W-1:0]      i_cmd;
    logic [BLK_W-1:0]      i_block_number;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [STAT_W-1:0]     o_status;
    logic [BLK_W-1:0]      o_allocated_block;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    int                    pending;
    int                    fail_count;

    // geometry as last written, used only to aim block numbers
    int st_total;
    int st_inode;
    int st_data;
    bit send_quiet;
    bit recv_quiet;

    block_bitmap_allocator u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_cmd             (i_cmd),
        .i_block_number    (i_block_number),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_status          (o_status),
        .o_allocated_block (o_allocated_block),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    bba_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_in_stall        (o_in_stall),
        .i_cmd             (i_cmd),
        .i_block_number    (i_block_number),
        .i_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .i_status          (o_status),
        .i_allocated_block (o_allocated_block),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_pending         (pending),
        .o_fail_count      (fail_count)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("testbench: errors");
        $finish;
    end

    // result side: random stall per beat, two long hold-offs to back the block up
    initial begin
        int hold;
        int beats;
        beats = 0;
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 39) == 0)
                recv_quiet = !recv_quiet;
            if (beats == 300 || beats == 800)
                hold = 400;
            else
                hold = recv_quiet ? 0 : $urandom_range(0, 18);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            beats++;
        end
    end

    // offer one command beat after a random gap, return once it is taken
    task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [BLK_W-1:0] blk);
        int gap;
        if ($urandom_range(0, 39) == 0)
            send_quiet = !send_quiet;
        gap = send_quiet ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_cmd          <= cmd;
        i_block_number <= blk;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // mostly commands on blocks near the scan range, some anywhere, some on edges
    task automatic send_random(input int count);
        int               n;
        int               lim;
        int               lo;
        int               pick;
        int               blk;
        logic [CMD_W-1:0] cmd;
        for (n = 0; n < count; n++) begin
            lim  = st_total < MAP_BLOCKS ? st_total : MAP_BLOCKS;
            lo   = 2 + st_inode / 8 + 1 + st_total / 4096 + 1;
            pick = $urandom_range(0, 99);
            if (pick < 45)
                cmd = CMD_ALLOC;
            else if (pick < 80)
                cmd = CMD_FREE;
            else if (pick < 95)
                cmd = CMD_MARK;
            else
                cmd = CMD_UNUSED;
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                blk = $urandom_range(0, lim + 7);
            end else if (pick < 85) begin
                blk = $urandom_range(0, MAP_BLOCKS - 1);
            end else begin
                case ($urandom_range(0, 5))
                    0:       blk = 0;
                    1:       blk = MAP_BLOCKS - 1;
                    2:       blk = lo - 1;
                    3:       blk = lo;
                    4:       blk = lo + st_data - 1;
                    default: blk = lo + st_data;
                endcase
            end
            if (blk > MAP_BLOCKS - 1)
                blk = MAP_BLOCKS - 1;
            send_beat(cmd, blk[BLK_W-1:0]);
        end
    endtask

    // stop offering and wait for every reply
    task automatic drain;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_TOTAL: st_total = int'(data[TOTAL_W-1:0]);
            CFG_INODE: st_inode = int'(data[INODE_W-1:0]);
            CFG_DATA:  st_data  = int'(data[DATA_W-1:0]);
            default:   ;
        endcase
    endtask

    // idle the block, load a new geometry, let the bounds settle, then run
    task automatic run_phase(input logic [CFG_DATA_W-1:0] total,
                             input logic [CFG_DATA_W-1:0] inode,
                             input logic [CFG_DATA_W-1:0] data,
                             input bit spare, input int count);
        drain;
        repeat (8) @(posedge i_clk);
        write_reg(CFG_TOTAL, total);
        write_reg(CFG_INODE, inode);
        write_reg(CFG_DATA, data);
        if (spare)
            write_reg(CFG_SPARE, CFG_DATA_W'($urandom_range(0, 4095)));
        i_cfg_valid <= 1'b0;
        repeat (4) @(posedge i_clk);
        send_random(count);
    endtask

    // main sequence
    initial begin
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_cmd          <= CMD_ALLOC;
        i_block_number <= '0;
        i_cfg_valid    <= 1'b0;
        i_cfg_index    <= CFG_TOTAL;
        i_cfg_data     <= '0;
        st_total   = int'(TOTAL_RST);
        st_inode   = int'(INODE_RST);
        st_data    = int'(DATA_RST);
        send_quiet = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset geometry: data region is blocks 29 to 993
        send_beat(CMD_ALLOC, 10'd1023);       // below the region, bit stays set
        send_beat(CMD_ALLOC, 10'd0);
        send_beat(CMD_FREE, 10'd0);           // free below the region
        send_beat(CMD_FREE, 10'd29);          // double free
        send_beat(CMD_MARK, 10'd29);
        send_beat(CMD_FREE, 10'd29);
        send_beat(CMD_MARK, 10'd1023);
        send_beat(CMD_FREE, 10'd1023);        // free above the region
        send_beat(CMD_MARK, 10'd993);
        send_beat(CMD_FREE, 10'd993);         // last block of the region
        send_beat(CMD_FREE, 10'd994);
        send_beat(CMD_FREE, 10'd28);
        send_beat(CMD_UNUSED, 10'd1023);
        send_beat(CMD_UNUSED, 10'd0);
        send_beat(CMD_MARK, 10'd0);           // mark of a used block
        send_beat(CMD_MARK, 10'd2);
        send_beat(CMD_ALLOC, 10'd512);
        send_beat(CMD_ALLOC, 10'd341);
        send_random(150);

        // small volumes fill up and report no free block
        run_phase(12'd48, 12'd0, 12'd40, 1'b0, 150);
        // empty scan range, plus a write to the spare index
        run_phase(12'd0, 12'd200, 12'd965, 1'b1, 40);
        // widest scan bound, largest inode area, widest region
        run_phase(12'hFFF, 12'd4095, 12'd2047, 1'b0, 150);
        // empty data region
        run_phase(12'd100, 12'd80, 12'd0, 1'b0, 100);
        run_phase(12'd64, 12'd8, 12'd1024, 1'b0, 150);
        run_phase(12'd1024, 12'd200, 12'd965, 1'b0, 150);
        run_phase(12'd33, 12'd7, 12'd20, 1'b0, 150);

        drain;
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
